// ----- rtl/ccov_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccov_pkg
// Shared codes and command types for the CIGAR coverage accumulator.
// ----------------------------------------------------------------------------
package ccov_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_CIGAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // strand filter modes
    localparam logic [1:0] STRAND_BOTH = 2'd0;
    localparam logic [1:0] STRAND_FWD  = 2'd1;
    localparam logic [1:0] STRAND_REV  = 2'd2;

    // CIGAR characters
    localparam logic [7:0] CH_M  = 8'h4D;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_N  = 8'h4E;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;

    localparam int COV_W = 16;

    // span of consecutive counters to bump: from_pos up to, not including, to_pos
    typedef struct packed {
        logic        go;
        logic [1:0]  ref_idx;
        logic [31:0] from_pos;
        logic [31:0] to_pos;
    } span_cmd_t;

    typedef struct packed {
        logic        go;
        logic        in_range;
        logic [1:0]  ref_idx;
        logic [13:0] pos;
    } read_cmd_t;

    typedef struct packed {
        logic             idle;
        logic             res_valid;
        logic [COV_W-1:0] coverage;
    } eng_status_t;

endpackage

// ----- rtl/ccov_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccov_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ccov_ram #(
    parameter int              WIDTH = 16,
    parameter longint unsigned DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold the last read word while re is low
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/ccov_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccov_parser
// Alignment state and CIGAR parsing; issues span and read commands.
// ----------------------------------------------------------------------------
module ccov_parser #(
    parameter int MAX_REFS    = 4,
    parameter int MAX_REF_LEN = 16384
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [1:0]            op,
    input  logic [1:0]            ref_sel,
    input  logic [13:0]           position,
    input  logic                  reverse_strand,
    input  logic [7:0]            cigar_byte,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,
    output ccov_pkg::span_cmd_t   span_cmd,
    output ccov_pkg::read_cmd_t   read_cmd
);

    logic [1:0]  strand_mode_reg;
    logic [1:0]  cur_ref_reg, cur_ref_next;
    logic [31:0] cur_pos_reg, cur_pos_next;
    logic [31:0] len_reg, len_next;
    logic        pass_reg, pass_next;

    logic        is_digit;
    logic        is_match;
    logic        is_skip;
    logic        ref_ok;
    logic [3:0]  digit;
    logic [35:0] len_x10;
    logic [32:0] pos_sum;
    logic [31:0] pos_sat;
    logic [31:0] span_end;

    assign is_digit = (cigar_byte >= ccov_pkg::CH_0) && (cigar_byte <= ccov_pkg::CH_9);
    assign is_match = (cigar_byte == ccov_pkg::CH_M) || (cigar_byte == ccov_pkg::CH_X)
                   || (cigar_byte == ccov_pkg::CH_EQ);
    assign is_skip  = (cigar_byte == ccov_pkg::CH_D) || (cigar_byte == ccov_pkg::CH_N);
    assign digit    = 4'(cigar_byte - ccov_pkg::CH_0);
    assign len_x10  = 36'({len_reg, 3'b000}) + 36'({len_reg, 1'b0}) + 36'(digit);
    assign ref_ok   = 7'(cur_ref_reg) < 7'(MAX_REFS);

    // clip the span at the end of the reference, saturate the position itself
    assign pos_sum  = 33'(cur_pos_reg) + 33'(len_reg);
    assign pos_sat  = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
    assign span_end = (pos_sum > 33'(MAX_REF_LEN)) ? 32'(MAX_REF_LEN) : pos_sum[31:0];

    always_comb
    begin
        cur_ref_next = cur_ref_reg;
        cur_pos_next = cur_pos_reg;
        len_next     = len_reg;
        pass_next    = pass_reg;
        span_cmd     = '0;
        read_cmd     = '0;
        if (accept)
        begin
            unique case (op)
                ccov_pkg::OP_BEGIN:
                begin
                    cur_ref_next = ref_sel;
                    cur_pos_next = 32'(position);
                    len_next     = '0;
                    case (strand_mode_reg)
                        ccov_pkg::STRAND_BOTH: pass_next = 1'b1;
                        ccov_pkg::STRAND_FWD:  pass_next = !reverse_strand;
                        ccov_pkg::STRAND_REV:  pass_next = reverse_strand;
                        default:               pass_next = 1'b0;
                    endcase
                end
                ccov_pkg::OP_CIGAR:
                begin
                    if (is_digit)
                    begin
                        len_next = (len_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : len_x10[31:0];
                    end
                    else
                    begin
                        if (is_match)
                        begin
                            span_cmd.go       = pass_reg && ref_ok;
                            span_cmd.ref_idx  = cur_ref_reg;
                            span_cmd.from_pos = cur_pos_reg;
                            span_cmd.to_pos   = span_end;
                            cur_pos_next      = pos_sat;
                        end
                        else if (is_skip)
                        begin
                            cur_pos_next = pos_sat;
                        end
                        len_next = '0;
                    end
                end
                ccov_pkg::OP_READ:
                begin
                    read_cmd.go       = 1'b1;
                    read_cmd.ref_idx  = ref_sel;
                    read_cmd.pos      = position;
                    read_cmd.in_range = (7'(ref_sel) < 7'(MAX_REFS))
                                     && (32'(position) < 32'(MAX_REF_LEN));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strand_mode_reg <= ccov_pkg::STRAND_BOTH;
            cur_ref_reg     <= '0;
            cur_pos_reg     <= '0;
            len_reg         <= '0;
            pass_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                strand_mode_reg <= cfg_wr_data;
            end
            cur_ref_reg <= cur_ref_next;
            cur_pos_reg <= cur_pos_next;
            len_reg     <= len_next;
            pass_reg    <= pass_next;
        end
    end

endmodule

// ----- rtl/ccov_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccov_engine
// Coverage store sequencer: clearing pass, per-base read-modify-write, reads.
// ----------------------------------------------------------------------------
module ccov_engine #(
    parameter int MAX_REFS    = 4,
    parameter int MAX_REF_LEN = 16384,
    parameter int COUNT_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ccov_pkg::span_cmd_t   span_cmd,
    input  ccov_pkg::read_cmd_t   read_cmd,
    input  logic                  res_ready,
    output ccov_pkg::eng_status_t status
);

    localparam longint unsigned DEPTH  = longint'(MAX_REFS) * longint'(MAX_REF_LEN);
    localparam int              ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SPAN  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;

    localparam logic [ccov_pkg::COV_W-1:0] COV_ZERO = '0;

    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [1:0]            span_ref_reg, span_ref_next;
    logic [31:0]           cursor_reg, cursor_next;
    logic [31:0]           to_reg, to_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]     wr_addr_reg, wr_addr_next;
    logic                  rd_zero_reg, rd_zero_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] r, input logic [31:0] p);
        return ADDR_W'(longint'(r) * longint'(MAX_REF_LEN)) + ADDR_W'(p);
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        span_ref_next = span_ref_reg;
        cursor_next   = cursor_reg;
        to_next       = to_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        rd_zero_next  = rd_zero_reg;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        status.idle      = (state_reg == ST_IDLE);
        status.res_valid = 1'b0;
        status.coverage  = COV_ZERO;

        // write half of the read-modify-write; addresses within a span never repeat
        ram_we    = wr_pend_reg;
        ram_waddr = wr_addr_reg;
        ram_wdata = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (span_cmd.go)
                begin
                    span_ref_next = span_cmd.ref_idx;
                    cursor_next   = span_cmd.from_pos;
                    to_next       = span_cmd.to_pos;
                    state_next    = ST_SPAN;
                end
                else if (read_cmd.go)
                begin
                    ram_re       = read_cmd.in_range;
                    ram_raddr    = addr_of(read_cmd.ref_idx, 32'(read_cmd.pos));
                    rd_zero_next = !read_cmd.in_range;
                    state_next   = ST_RD;
                end
            end
            ST_SPAN:
            begin
                if (cursor_reg < to_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = addr_of(span_ref_reg, cursor_reg);
                    cursor_next  = cursor_reg + 32'd1;
                    wr_pend_next = 1'b1;
                    wr_addr_next = ram_raddr;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                status.res_valid = 1'b1;
                status.coverage  = rd_zero_reg ? COV_ZERO : ccov_pkg::COV_W'(ram_rdata);
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            wr_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            wr_pend_reg  <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_ref_reg <= span_ref_next;
        cursor_reg   <= cursor_next;
        to_reg       <= to_next;
        wr_addr_reg  <= wr_addr_next;
        rd_zero_reg  <= rd_zero_next;
    end

    ccov_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_cmd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (span_cmd.go || read_cmd.go) |-> state_reg == ST_IDLE)
        else $error("command issued while store sequencer busy");

    a_write_follows_span: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> $past(state_reg) == ST_SPAN)
        else $error("increment write without a preceding span read");

    a_span_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPAN && cursor_reg < to_reg) |-> to_reg <= 32'(MAX_REF_LEN))
        else $error("span reaches past the end of the reference");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD && !res_ready) |=> state_reg == ST_RD && $stable(ram_rdata))
        else $error("pending coverage result lost");
`endif

endmodule

// ----- rtl/cigar_coverage_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_coverage_accumulator
// Per-base read coverage built from CIGAR strings, held in one counter RAM.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  begin, CIGAR byte or read item
//  m_axis    out  m_axis_tvalid / m_axis_tready  coverage for each read item
//  cfg       in   cfg_wr_en                      strand_mode
//
// Begin, digit, D, N and other CIGAR bytes, and an M, X or = byte that fails
// the strand filter, only update the parser state. One that passes has the store
// do one read-modify-write per base inside the reference, pipelined through
// the registered RAM read, with s_axis_tready low. A read item holds it low
// until its result enters the output register. After reset a clearing pass
// writes zeros over MAX_REFS * MAX_REF_LEN entries (65536 by default) with s_axis_tready low.
// A waiting result sits in the output register; a second read stalls until
// that register frees.
// ----------------------------------------------------------------------------
module cigar_coverage_accumulator #(
    parameter int MAX_REFS    = 4,
    parameter int MAX_REF_LEN = 16384,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // ref_sel[1:0], position[15:2], reverse_strand[16], cigar_byte[24:17], zero
    input  logic [31:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // coverage[15:0]
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data
);

    ccov_pkg::span_cmd_t   span_cmd;
    ccov_pkg::read_cmd_t   read_cmd;
    ccov_pkg::eng_status_t status;

    logic        accept;
    logic        res_ready;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    assign s_axis_tready = status.idle;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign res_ready     = !out_valid_reg || m_axis_tready;

    ccov_parser #(
        .MAX_REFS    (MAX_REFS),
        .MAX_REF_LEN (MAX_REF_LEN)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .op             (s_axis_tuser),
        .ref_sel        (s_axis_tdata[1:0]),
        .position       (s_axis_tdata[15:2]),
        .reverse_strand (s_axis_tdata[16]),
        .cigar_byte     (s_axis_tdata[24:17]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .span_cmd       (span_cmd),
        .read_cmd       (read_cmd)
    );

    ccov_engine #(
        .MAX_REFS    (MAX_REFS),
        .MAX_REF_LEN (MAX_REF_LEN),
        .COUNT_BITS  (COUNT_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .span_cmd  (span_cmd),
        .read_cmd  (read_cmd),
        .res_ready (res_ready),
        .status    (status)
    );

    // output register: load when empty or being emptied
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= status.res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && status.res_valid)
        begin
            out_data_reg <= status.coverage;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
